// ===== rtl/tbdl_pkg.sv =====
// ----------------------------------------------------------------------------
// tbdl_pkg
// shared types and constants of the two-beam direction event logger: item
// layouts, microcode word format, opcodes, jump conditions and codes
// ----------------------------------------------------------------------------
package tbdl_pkg;

    // sequencer step counter width
    localparam int PC_W = 3;

    // configuration register indexes
    localparam logic [1:0] CFG_FAR_LIMIT   = 2'd0;
    localparam logic [1:0] CFG_NEAR_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_PAIR_WINDOW = 2'd2;
    localparam logic [1:0] CFG_TIME_SHIFT  = 2'd3;

    // configuration reset values
    localparam logic [15:0] FAR_LIMIT_RST   = 16'd700;
    localparam logic [15:0] NEAR_LIMIT_RST  = 16'd10;
    localparam logic [15:0] PAIR_WINDOW_RST = 16'd1;
    localparam logic [3:0]  TIME_SHIFT_RST  = 4'd1;

    // result word kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_TIME   = 2'd1;
    localparam logic [1:0] KIND_ENTRY  = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    // passage codes
    localparam logic [1:0] PASS_NONE    = 2'd0;
    localparam logic [1:0] PASS_ENTERED = 2'd1;
    localparam logic [1:0] PASS_EXITED  = 2'd2;

    localparam logic [15:0] END_MARK  = 16'hFFFF;
    localparam logic [15:0] ENTRY_BIT = 16'h8000;

    // request types
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_DRAIN  = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [15:0] range_one;
        logic [15:0] range_two;
        logic        read_failed;
        logic [31:0] now_seconds;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  word_kind;
        logic [1:0]  passage;
        logic        skipped;
        logic [15:0] out_word;
        logic        last;
    } out_item_t;

    // datapath operations
    typedef enum logic [2:0] {
        OP_FETCH,
        OP_NOP,
        OP_SENSE,
        OP_EMIT_TIME,
        OP_READ,
        OP_EMIT_ENTRY,
        OP_EMIT_END
    } op_t;

    // jump conditions
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_ITEM,
        COND_DRAIN,
        COND_EMPTY,
        COND_MORE
    } cond_t;

    typedef struct packed {
        op_t             op;
        logic            need_slot;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    // status flags from the datapath into the sequencer
    typedef struct packed {
        logic item_valid;
        logic drain;
        logic empty;
        logic more;
        logic slot_free;
    } seq_flags_t;

    // control from the sequencer into the datapath
    typedef struct packed {
        op_t  op;
        logic fire;
    } ctrl_t;

endpackage

// ===== rtl/tbdl_seq.sv =====
// ----------------------------------------------------------------------------
// tbdl_seq
// microcode sequencer: program rom, step counter and conditional jumps
// ----------------------------------------------------------------------------
module tbdl_seq
    import tbdl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  seq_flags_t flags,
    output ctrl_t      ctrl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    ctrl_word_t      word;
    logic            cond_hit;
    logic            fire;

    // program
    function automatic ctrl_word_t rom_word(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        begin
            case (pc)
                3'd0:    w = '{OP_FETCH,      1'b0, COND_NO_ITEM, 3'd0};
                3'd1:    w = '{OP_NOP,        1'b0, COND_DRAIN,   3'd3};
                3'd2:    w = '{OP_SENSE,      1'b1, COND_ALWAYS,  3'd0};
                3'd3:    w = '{OP_NOP,        1'b0, COND_EMPTY,   3'd0};
                3'd4:    w = '{OP_EMIT_TIME,  1'b1, COND_NEVER,   3'd0};
                3'd5:    w = '{OP_READ,       1'b0, COND_NEVER,   3'd0};
                3'd6:    w = '{OP_EMIT_ENTRY, 1'b1, COND_MORE,    3'd5};
                3'd7:    w = '{OP_EMIT_END,   1'b1, COND_ALWAYS,  3'd0};
                default: w = '{OP_FETCH,      1'b0, COND_NEVER,   3'd0};
            endcase
            return w;
        end
    endfunction

    assign word = rom_word(pc_reg);

    always_comb
    begin
        case (word.cond)
            COND_NEVER:   cond_hit = 1'b0;
            COND_ALWAYS:  cond_hit = 1'b1;
            COND_NO_ITEM: cond_hit = !flags.item_valid;
            COND_DRAIN:   cond_hit = flags.drain;
            COND_EMPTY:   cond_hit = flags.empty;
            COND_MORE:    cond_hit = flags.more;
            default:      cond_hit = 1'b0;
        endcase
    end

    // a step that writes the output register waits for a free slot
    assign fire = !(word.need_slot && !flags.slot_free);

    always_comb
    begin
        pc_next = pc_reg;
        if (fire)
        begin
            pc_next = cond_hit ? word.target : PC_W'(pc_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    assign ctrl.op   = word.op;
    assign ctrl.fire = fire;

endmodule

// ===== rtl/two_beam_direction_event_logger.sv =====
// ----------------------------------------------------------------------------
// two_beam_direction_event_logger
// doorway direction detector with two range sensors and a drainable event log
// ----------------------------------------------------------------------------
// Works on one item at a time under a small microcode program. A sensor sample
// passes fetch, decode and evaluate steps from transfer to its status result
// and gives one result. A drain of an empty log gives nothing; a drain of n
// entries gives a time word, the n entries and an end marker. The log memory
// gives one registered read per step, so each entry needs a read step and an
// output step. Output stalls hold any step that writes the output register.
// The log is a plain memory with no clearing pass: entries are only read after being written.
// Configuration writes are always ready and should only be issued while idle.
module two_beam_direction_event_logger
    import tbdl_pkg::*;
#(
    parameter int LOG_DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input item channel
    input  logic        item_valid,
    output logic        item_stall,
    input  in_item_t    item,
    // result channel
    output logic        result_valid,
    input  logic        result_stall,
    output out_item_t   result,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

    // configuration
    logic [15:0] far_limit_reg;
    logic [15:0] near_limit_reg;
    logic [15:0] pair_window_reg;
    logic [3:0]  time_shift_reg;

    // detector state
    logic        present_one_reg, present_one_next;
    logic        present_two_reg, present_two_next;
    logic [31:0] release_one_reg, release_one_next;
    logic [31:0] release_two_reg, release_two_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;

    // current item and output slot
    in_item_t    cur_reg;
    out_item_t   result_reg, result_next;
    logic        result_valid_reg, result_valid_next;

    // event log memory and its read data
    logic [15:0] log_mem [LOG_DEPTH];
    logic [15:0] rd_data_reg;

    seq_flags_t  flags;
    ctrl_t       ctrl;

    // sample evaluation
    logic        in_one, in_two;
    logic        rel_one, rel_two;
    logic [31:0] since_two, since_one;
    logic        entry_hit, exit_hit;
    logic [31:0] release_one_new;
    logic [15:0] shifted;
    logic [15:0] log_word;
    logic        log_write;

    logic do_fetch, do_sense, do_time, do_read, do_entry, do_end;

    tbdl_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    assign do_fetch = ctrl.fire && (ctrl.op == OP_FETCH);
    assign do_sense = ctrl.fire && (ctrl.op == OP_SENSE);
    assign do_time  = ctrl.fire && (ctrl.op == OP_EMIT_TIME);
    assign do_read  = ctrl.fire && (ctrl.op == OP_READ);
    assign do_entry = ctrl.fire && (ctrl.op == OP_EMIT_ENTRY);
    assign do_end   = ctrl.fire && (ctrl.op == OP_EMIT_END);

    // handshakes: items are taken only in the fetch step
    assign item_stall   = (ctrl.op != OP_FETCH);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    assign flags.item_valid = item_valid;
    assign flags.drain      = (cur_reg.req_type == REQ_DRAIN);
    assign flags.empty      = (wp_reg == '0);
    assign flags.more       = (rd_idx_reg != wp_reg);
    assign flags.slot_free  = !result_valid_reg || !result_stall;

    // presence: above near limit and at most far limit
    assign in_one = (cur_reg.range_one > near_limit_reg) && (cur_reg.range_one <= far_limit_reg);
    assign in_two = (cur_reg.range_two > near_limit_reg) && (cur_reg.range_two <= far_limit_reg);
    assign rel_one = !in_one && present_one_reg;
    assign rel_two = !in_two && present_two_reg;

    // sensor one goes first, so its new release time feeds the exit test
    assign release_one_new = rel_one ? cur_reg.now_seconds : release_one_reg;
    assign since_two = cur_reg.now_seconds - release_two_reg;
    assign since_one = cur_reg.now_seconds - release_one_new;
    assign entry_hit = rel_one && (since_two < {16'd0, pair_window_reg});
    assign exit_hit  = rel_two && (since_one < {16'd0, pair_window_reg});

    assign shifted  = cur_reg.now_seconds[15:0] >> time_shift_reg;
    assign log_word = entry_hit ? (shifted | ENTRY_BIT) : (shifted & ~ENTRY_BIT);
    // entry and exit together cancel
    assign log_write = do_sense && !cur_reg.read_failed && (entry_hit != exit_hit);

    always_comb
    begin
        present_one_next  = present_one_reg;
        present_two_next  = present_two_reg;
        release_one_next  = release_one_reg;
        release_two_next  = release_two_reg;
        wp_next           = wp_reg;
        rd_idx_next       = rd_idx_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        if (do_sense)
        begin
            result_next       = '{KIND_STATUS, PASS_NONE, 1'b0, 16'd0, 1'b1};
            result_valid_next = 1'b1;
            if (cur_reg.read_failed)
            begin
                result_next.skipped = 1'b1;
            end
            else
            begin
                present_one_next = in_one;
                present_two_next = in_two;
                release_one_next = release_one_new;
                if (rel_two)
                begin
                    release_two_next = cur_reg.now_seconds;
                end
                if (log_write)
                begin
                    result_next.passage = entry_hit ? PASS_ENTERED : PASS_EXITED;
                    wp_next = (wp_reg == AW'(LOG_DEPTH - 1)) ? '0 : AW'(wp_reg + 1'b1);
                end
            end
        end

        if (do_time)
        begin
            result_next = '{KIND_TIME, PASS_NONE, 1'b0, cur_reg.now_seconds[15:0], 1'b0};
            result_valid_next = 1'b1;
            rd_idx_next = '0;
        end

        if (do_read)
        begin
            rd_idx_next = AW'(rd_idx_reg + 1'b1);
        end

        if (do_entry)
        begin
            result_next = '{KIND_ENTRY, PASS_NONE, 1'b0, rd_data_reg, 1'b0};
            result_valid_next = 1'b1;
        end

        if (do_end)
        begin
            result_next = '{KIND_END, PASS_NONE, 1'b0, END_MARK, 1'b1};
            result_valid_next = 1'b1;
            wp_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_one_reg  <= 1'b0;
            present_two_reg  <= 1'b0;
            release_one_reg  <= '0;
            release_two_reg  <= '0;
            wp_reg           <= '0;
            rd_idx_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            present_one_reg  <= present_one_next;
            present_two_reg  <= present_two_next;
            release_one_reg  <= release_one_next;
            release_two_reg  <= release_two_next;
            wp_reg           <= wp_next;
            rd_idx_reg       <= rd_idx_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (do_fetch && item_valid)
        begin
            cur_reg <= item;
        end
    end

    // event log memory
    always_ff @(posedge clk)
    begin
        if (log_write)
        begin
            log_mem[wp_reg] <= log_word;
        end
        if (do_read)
        begin
            rd_data_reg <= log_mem[rd_idx_reg];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            far_limit_reg   <= FAR_LIMIT_RST;
            near_limit_reg  <= NEAR_LIMIT_RST;
            pair_window_reg <= PAIR_WINDOW_RST;
            time_shift_reg  <= TIME_SHIFT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FAR_LIMIT:   far_limit_reg   <= cfg_data;
                CFG_NEAR_LIMIT:  near_limit_reg  <= cfg_data;
                CFG_PAIR_WINDOW: pair_window_reg <= cfg_data;
                CFG_TIME_SHIFT:  time_shift_reg  <= cfg_data[3:0];
                default:         far_limit_reg   <= far_limit_reg;
            endcase
        end
    end

    // drain starts only with something in the log
    a_time_needs_entries: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.op == OP_EMIT_TIME |-> wp_reg != '0)
        else $error("drain started on empty log");

    // each entry output follows a read that stays below the write pointer
    a_entry_read_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.op == OP_EMIT_ENTRY |-> rd_idx_reg != '0 && rd_idx_reg <= wp_reg)
        else $error("log read past write pointer");

    // a pending end marker means the log was cleared
    a_end_clears_log: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.word_kind == KIND_END |-> wp_reg == '0)
        else $error("end marker with log not cleared");

endmodule
